/* design/fle_pkg.sv */
// fle_pkg: shared constants and types for the log2/exp2 approximation block
// no dependencies; imported by every module in design/
package fle_pkg;

	// bit pattern of 1.0f and fixed-point scale constants
	localparam logic [31:0] ONE_BITS  = 32'd1065353216;
	localparam logic [31:0] TWO_UNIT  = 32'd16777216;
	localparam logic [25:0] FOUR_UNIT = 26'd33554432;

	// ceil(2^25 / 3), exact floor division by three for operands below 2^25
	localparam logic [23:0] RECIP3    = 24'd11184811;
	localparam int unsigned RECIP3_SH = 25;

	// square root pipeline shape: 25 result bits, five per stage
	localparam int unsigned SQRT_STAGES = 5;
	localparam int unsigned SQRT_ITERS  = 5;

	// operand word handed from the first stage to the log2 pipeline
	typedef struct packed {
		logic        second;
		logic [31:0] d;
		logic [23:0] hh;
		logic [22:0] hl;
	} log_in_t;

endpackage

/* design/fle_log2_pipe.sv */
// fle_log2_pipe: four-stage log2 back end (quadratic correction, divide by three,
// fixed-to-float conversion with round to nearest even); depends on fle_pkg
module fle_log2_pipe import fle_pkg::*; (
	input  logic        clk,
	input  logic        en,
	input  log_in_t     op,
	output logic [31:0] y
);

	// stage a: square term, difference and reciprocal multiply
	logic [24:0] sq_sum_c;
	logic [23:0] sq_c;
	logic [23:0] diff_c;
	logic [46:0] prod_c;
	logic [46:0] prod_a;
	logic [31:0] d_a;
	logic        second_a;

	assign sq_sum_c = 25'(op.hh) + 25'(op.hl[22:10]);
	assign sq_c     = sq_sum_c[24:1];
	assign diff_c   = {1'b0, op.d[22:0]} - sq_c;
	assign prod_c   = diff_c[22:0] * RECIP3;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_a   <= prod_c;
			d_a      <= op.d;
			second_a <= op.second;
		end
	end

	// stage b: add correction, take magnitude
	logic [21:0] q_c;
	logic [31:0] dsum_c;
	logic [31:0] mag_b;
	logic        neg_b;

	assign q_c    = prod_a[RECIP3_SH +: 22];
	assign dsum_c = d_a + (second_a ? {10'd0, q_c} : 32'd0);

	always_ff @(posedge clk) begin
		if (en) begin
			neg_b <= dsum_c[31];
			mag_b <= dsum_c[31] ? (32'd0 - dsum_c) : dsum_c;
		end
	end

	// stage c: leading one position
	logic [4:0]  p_c;
	logic [31:0] mag_c;
	logic [4:0]  p_cs;
	logic        neg_c;
	logic        zero_c;

	always_comb begin
		p_c = 5'd0;
		for (int i = 0; i < 32; i++) begin
			if (mag_b[i]) p_c = 5'(i);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_c  <= mag_b;
			p_cs   <= p_c;
			neg_c  <= neg_b;
			zero_c <= (mag_b == 32'd0);
		end
	end

	// stage d: normalise, round and pack
	logic [3:0]  sh_c;
	logic [31:0] rmask_c;
	logic [31:0] half_c;
	logic [31:0] rem_c;
	logic [23:0] sig_c;
	logic [24:0] sig_r_c;
	logic        up_c;
	logic [7:0]  exp_c;
	logic [31:0] y_c;

	always_comb begin
		sh_c    = 4'd0;
		rmask_c = 32'd0;
		half_c  = 32'd0;
		rem_c   = 32'd0;
		up_c    = 1'b0;
		if (p_cs <= 5'd23) begin
			sig_c = 24'(mag_c << (5'd23 - p_cs));
		end else begin
			sh_c    = 4'(p_cs - 5'd23);
			rmask_c = (32'd1 << sh_c) - 32'd1;
			half_c  = 32'd1 << (sh_c - 4'd1);
			rem_c   = mag_c & rmask_c;
			sig_c   = 24'(mag_c >> sh_c);
			up_c    = (rem_c > half_c) || ((rem_c == half_c) && sig_c[0]);
		end
		sig_r_c = {1'b0, sig_c} + {24'd0, up_c};
		exp_c   = 8'(p_cs) + 8'd104 + {7'd0, sig_r_c[24]};
		if (zero_c) begin
			y_c = 32'd0;
		end else begin
			y_c = {neg_c, exp_c, sig_r_c[24] ? 23'd0 : sig_r_c[22:0]};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			y <= y_c;
		end
	end

endmodule

/* design/fle_sqrt_pipe.sv */
// fle_sqrt_pipe: floor square root of (s * 2^23), restoring digit recurrence,
// five result bits per stage over five stages; depends on fle_pkg
module fle_sqrt_pipe import fle_pkg::*; (
	input  logic        clk,
	input  logic        en,
	input  logic [25:0] s,
	output logic [24:0] root
);

	localparam int unsigned RAD_W = 2 * SQRT_STAGES * SQRT_ITERS;

	logic [26:0]      rem_s  [SQRT_STAGES:0];
	logic [24:0]      root_s [SQRT_STAGES:0];
	logic [RAD_W-1:0] rad_s  [SQRT_STAGES:0];

	// stage zero is the radicand itself, padded to an even bit count
	assign rem_s[0]  = 27'd0;
	assign root_s[0] = 25'd0;
	assign rad_s[0]  = RAD_W'({s, 23'd0});

	for (genvar k = 1; k <= SQRT_STAGES; k++) begin : g_stage
		logic [26:0]      r_c;
		logic [24:0]      q_c;
		logic [RAD_W-1:0] w_c;
		logic [26:0]      r2;
		logic [26:0]      trial;

		// five digit steps
		always_comb begin
			r_c   = rem_s[k-1];
			q_c   = root_s[k-1];
			w_c   = rad_s[k-1];
			r2    = 27'd0;
			trial = 27'd0;
			for (int i = 0; i < SQRT_ITERS; i++) begin
				r2    = {r_c[24:0], w_c[RAD_W-1 -: 2]};
				trial = {q_c, 2'b01};
				if (r2 >= trial) begin
					r_c = r2 - trial;
					q_c = {q_c[23:0], 1'b1};
				end else begin
					r_c = r2;
					q_c = {q_c[23:0], 1'b0};
				end
				w_c = w_c << 2;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= r_c;
				root_s[k] <= q_c;
				rad_s[k]  <= w_c;
			end
		end
	end

	assign root = root_s[SQRT_STAGES];

endmodule

/* design/fast_log2_exp2_approx.sv */
// fast_log2_exp2_approx: top level, input decode, exp2 conversion, output stage
// depends on fle_pkg, fle_log2_pipe, fle_sqrt_pipe
//
// usage
// - argument channel: func, x_bits with arg_valid/arg_ready; one word per cycle
// - result channel: y_bits, range_flag with res_valid/res_ready
// - func selects log2 or exp2, first or second order; range_flag only on exp2
// - res_valid is the valid bit of the last stage; an accepted word passes every stage to reach it
// - throughput is one word per cycle unless stalled; the exp2 square root
//   is spread over five stages and sets the depth, the log2 path is padded to match
// - all stages advance together; when the result is held by the receiver the
//   whole pipeline holds and arg_ready drops, nothing is lost or repeated
// - reset clears every valid bit; the pipeline comes up empty and ready
// - no configuration, no state between words
module fast_log2_exp2_approx import fle_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        arg_valid,
	output logic        arg_ready,
	input  logic [1:0]  func,
	input  logic [31:0] x_bits,
	output logic        res_valid,
	input  logic        res_ready,
	output logic [31:0] y_bits,
	output logic        range_flag
);

	localparam int unsigned LAST = SQRT_STAGES + 2;

	logic en;
	logic v_s [LAST:1];

	// global advance
	assign en        = !v_s[LAST] || res_ready;
	assign arg_ready = en;
	assign res_valid = v_s[LAST];

	// stage 1 log2 operands
	logic [31:0] d_c;
	log_in_t     lop_c;
	assign d_c         = x_bits - ONE_BITS;
	assign lop_c.second = func[1];
	assign lop_c.d      = d_c;
	assign lop_c.hh     = d_c[22:11] * d_c[22:11];
	assign lop_c.hl     = d_c[22:11] * d_c[10:0];

	// stage 1 exp2 input conversion, trunc(x * 2^23) with saturation
	logic [7:0]  e_c;
	logic [22:0] man_c;
	logic [7:0]  rsh_c;
	logic [31:0] mag_c;
	logic [31:0] t_c;
	logic        sat_c;
	logic [25:0] f3_c;
	logic [25:0] s_c;

	always_comb begin
		e_c   = x_bits[30:23];
		man_c = x_bits[22:0];
		rsh_c = 8'd127 - e_c;
		mag_c = 32'd0;
		sat_c = 1'b0;
		t_c   = 32'd0;
		if (e_c == 8'hFF && man_c != 23'd0) begin
			sat_c = 1'b1;
		end else if (e_c >= 8'd135) begin
			sat_c = 1'b1;
			t_c   = x_bits[31] ? 32'h8000_0000 : 32'h7FFF_FFFF;
		end else if (e_c != 8'd0) begin
			if (e_c >= 8'd127) begin
				mag_c = {8'd0, 1'b1, man_c} << 3'(e_c - 8'd127);
			end else if (rsh_c < 8'd24) begin
				mag_c = {8'd0, 1'b1, man_c} >> rsh_c[4:0];
			end
			t_c = x_bits[31] ? (32'd0 - mag_c) : mag_c;
		end
		f3_c = {2'b0, t_c[22:0], 1'b0} + {3'b0, t_c[22:0]};
		s_c  = FOUR_UNIT - f3_c;
	end

	log_in_t     lop_s1;
	logic [25:0] s_s1;
	logic [31:0] t_s   [LAST-1:1];
	logic        sat_s [LAST:1];
	logic        ex_s  [LAST:1];
	logic        sec_s [LAST-1:1];

	always_ff @(posedge clk) begin
		if (en) begin
			lop_s1   <= lop_c;
			s_s1     <= s_c;
			t_s[1]   <= t_c;
			sat_s[1] <= sat_c & func[0];
			ex_s[1]  <= func[0];
			sec_s[1] <= func[1];
			for (int k = 2; k < LAST; k++) begin
				t_s[k]   <= t_s[k-1];
				sec_s[k] <= sec_s[k-1];
			end
			for (int k = 2; k <= LAST; k++) begin
				sat_s[k] <= sat_s[k-1];
				ex_s[k]  <= ex_s[k-1];
			end
		end
	end

	// valid bits travel with the words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= LAST; k++) v_s[k] <= 1'b0;
		end else if (en) begin
			v_s[1] <= arg_valid;
			for (int k = 2; k <= LAST; k++) v_s[k] <= v_s[k-1];
		end
	end

	// log2 back end, result lands at stage 5
	logic [31:0] ylog_s5;
	logic [31:0] ylog_s6;

	fle_log2_pipe u_log (
		.clk (clk),
		.en  (en),
		.op  (lop_s1),
		.y   (ylog_s5)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			ylog_s6 <= ylog_s5;
		end
	end

	// exp2 square root, result lands at stage 6
	logic [24:0] root_s6;

	fle_sqrt_pipe u_sqrt (
		.clk  (clk),
		.en   (en),
		.s    (s_s1),
		.root (root_s6)
	);

	// final exp2 sum and output register
	logic [31:0] t6_c;
	logic [31:0] yexp_c;
	assign t6_c   = t_s[LAST-1];
	assign yexp_c = sec_s[LAST-1]
		? (t6_c + TWO_UNIT - {7'd0, root_s6} - {9'd0, t6_c[22:0]} + ONE_BITS)
		: (t6_c + ONE_BITS);

	logic [31:0] y_s7;
	always_ff @(posedge clk) begin
		if (en) begin
			y_s7 <= ex_s[LAST-1] ? yexp_c : ylog_s6;
		end
	end

	assign y_bits     = y_s7;
	assign range_flag = sat_s[LAST];

	// checks
	a_flag_exp_only: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && range_flag |-> ex_s[LAST])
		else $error("range flag raised on a log2 word");

	a_take_enters: assert property (@(posedge clk) disable iff (!arst_n)
		arg_valid && arg_ready |=> v_s[1])
		else $error("accepted word missing from first stage");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |-> !arg_ready)
		else $error("argument taken while pipeline stalled");

	a_log_exp_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !ex_s[LAST] |-> y_bits[30:23] < 8'd137)
		else $error("log2 result exponent out of range");

endmodule

/* verif/fast_log2_exp2_approx_test.sv */
// fast_log2_exp2_approx_test: self-checking bench for the log2/exp2 approximation block
// depends on fle_pkg and fast_log2_exp2_approx; predicts each result word bit for bit
module fast_log2_exp2_approx_test;
	import fle_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] FN_LOG1 = 2'd0;
	localparam logic [1:0] FN_EXP1 = 2'd1;
	localparam logic [1:0] FN_LOG2 = 2'd2;
	localparam logic [1:0] FN_EXP2 = 2'd3;
	localparam logic [31:0] MANT_MASK = 32'h007F_FFFF;
	localparam logic [31:0] UNIT_ONE  = 32'h0080_0000;
	localparam int WATCHDOG_LIMIT = 2000;

	typedef struct packed {
		logic [31:0] y;
		logic        flag;
	} approx_t;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        arg_valid = 0;
	logic        arg_ready;
	logic [1:0]  func = '0;
	logic [31:0] x_bits = '0;
	logic        res_valid;
	logic        res_ready = 0;
	logic [31:0] y_bits;
	logic        range_flag;

	approx_t expected_q[$];
	int      errors = 0;
	int      idle_pct = 10;
	int      quiet_cycles = 0;

	fast_log2_exp2_approx dut (.*);

	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	// exact floor square root
	function automatic logic [31:0] floor_sqrt(input logic [63:0] v);
		logic [63:0] r;
		logic [63:0] b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r[31:0];
	endfunction

	// signed fixed value in units of 2^-23 to float, nearest even
	function automatic logic [31:0] fixed_to_float(input logic [31:0] v);
		logic [31:0] m, sig, rem, half;
		int p, sh;
		m = v[31] ? -v : v;
		if (m == 0) return 32'd0;
		p = 0;
		while (p < 31 && (m >> (p + 1)) != 0) p++;
		if (p <= 23) begin
			sig = m << (23 - p);
		end else begin
			sh = p - 23;
			rem = m & ((32'd1 << sh) - 1);
			half = 32'd1 << (sh - 1);
			sig = m >> sh;
			if (rem > half || (rem == half && sig[0])) sig++;
			if (sig == 32'd1 << 24) begin
				sig >>= 1;
				p++;
			end
		end
		return {v[31], 8'(p + 104), sig[22:0]};
	endfunction

	// truncate x*2^23 to int32, saturating
	function automatic logic [32:0] float_to_fixed(input logic [31:0] x);
		logic [7:0]  e;
		logic [31:0] mag, mant;
		e = x[30:23];
		mant = UNIT_ONE | (x & MANT_MASK);
		if (e == 8'hFF && x[22:0] != 0) return {1'b1, 32'd0};
		if (e >= 135) return {1'b1, x[31] ? 32'h8000_0000 : 32'h7FFF_FFFF};
		if (e == 0) return 33'd0;
		if (e >= 127) mag = mant << (e - 127);
		else mag = (127 - e >= 24) ? 32'd0 : mant >> (127 - e);
		return {1'b0, x[31] ? -mag : mag};
	endfunction

	function automatic approx_t approximate(input logic [1:0] fn, input logic [31:0] x);
		approx_t r;
		logic [31:0] d, f, hi, lo, sq, t, s;
		logic [32:0] conv;
		r.flag = 0;
		if (!fn[0]) begin
			d = x - ONE_BITS;
			if (fn == FN_LOG2) begin
				f = d & MANT_MASK;
				hi = f >> 11;
				lo = f & 32'd2047;
				sq = (hi * hi + ((hi * lo) >> 10)) >> 1;
				d = d + (f - sq) / 3;
			end
			r.y = fixed_to_float(d);
		end else begin
			conv = float_to_fixed(x);
			r.flag = conv[32];
			t = conv[31:0];
			r.y = t + ONE_BITS;
			if (fn == FN_EXP2) begin
				f = t & MANT_MASK;
				s = 32'(FOUR_UNIT) - 3 * f;
				r.y = t + TWO_UNIT - floor_sqrt(64'(s) * 64'(UNIT_ONE)) - f + ONE_BITS;
			end
		end
		return r;
	endfunction

	// send one word; valid held until accepted, dropped only while idling
	task automatic send_word(input logic [1:0] fn, input logic [31:0] x);
		while ($urandom_range(99) < idle_pct) begin
			arg_valid <= 0;
			@(posedge clk);
		end
		arg_valid <= 1;
		func <= fn;
		x_bits <= x;
		do @(posedge clk); while (!arg_ready);
		expected_q.push_back(approximate(fn, x));
	endtask

	// receiver stalls and result check
	always @(posedge clk) begin
		approx_t e;
		if (arst_n) begin
			if (res_valid && res_ready) begin
				if (expected_q.size() == 0) begin
					$error("result word with nothing expected: y_bits %h", y_bits);
					errors++;
				end else begin
					e = expected_q.pop_front();
					if (y_bits !== e.y) begin
						$error("y_bits expected %h actual %h", e.y, y_bits);
						errors++;
					end
					if (range_flag !== e.flag) begin
						$error("range_flag expected %b actual %b", e.flag, range_flag);
						errors++;
					end
				end
			end
			res_ready <= ($urandom_range(99) >= idle_pct);
		end
	end

	// watchdog on cycles with no accepted argument and no taken result
	always @(posedge clk) begin
		if ((arg_valid && arg_ready) || (res_valid && res_ready)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > WATCHDOG_LIMIT) begin
			$display("fast_log2_exp2_approx_test NOT OK");
			$finish;
		end
	end

	// stop sending and wait for every expected word
	task automatic drain();
		arg_valid <= 0;
		while (expected_q.size() != 0) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_float(input int lo_e, input int hi_e);
		return {1'($urandom), 8'($urandom_range(hi_e, lo_e)), 23'($urandom)};
	endfunction

	task automatic test_directed();
		logic [31:0] vals[12] = '{32'h0000_0000, 32'h8000_0000, 32'h3F80_0000,
			32'hFFFF_FFFF, 32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0000, 32'h0000_0001,
			32'h437F_FFFF, 32'h4380_0000, 32'hC380_0000, 32'h3F7F_FFFF};
		for (int i = 0; i < 12; i++) send_word(2'(i), vals[i]);
		for (int fn = 0; fn < 4; fn++) send_word(2'(fn), vals[(fn * 5 + 3) % 12]);
		for (int fn = 0; fn < 4; fn++) send_word(2'(fn), 32'h3400_0000);
	endtask

	// mostly in-range exponents, some anything-goes patterns
	task automatic test_random(input int n);
		logic [31:0] x;
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(3))
				0: x = $urandom;
				1: x = rand_float(100, 140);
				default: x = rand_float(118, 136);
			endcase
			send_word(2'($urandom), x);
		end
	endtask

	task automatic test_pause_until_empty();
		test_random(50);
		drain();
		test_random(50);
	endtask

	task automatic test_full_rate();
		idle_pct = 0;
		test_random(400);
		idle_pct = 10;
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_directed();
		test_random(600);
		test_pause_until_empty();
		test_full_rate();
		test_random(500);
		drain();
		repeat (20) @(posedge clk);
		if (errors == 0) $display("fast_log2_exp2_approx_test OK");
		else $display("fast_log2_exp2_approx_test NOT OK");
		$finish;
	end

endmodule
